// ===== hdl/mcfc_pkg.sv =====
// Shared types and constants for the motor CAN feedback and command block.
// Used by mcfc_div, mcfc_ctrl, mcfc_dp and the top level.
// No dependencies.
package mcfc_pkg;

  // Stream widths
  localparam int unsigned TDATA_IN_W  = 128;
  localparam int unsigned TUSER_IN_W  = 2;
  localparam int unsigned TDATA_OUT_W = 224;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // Count-to-angle scaling: 100 centidegrees times 256 fraction steps, times 256
  // for the fraction bits of counts_per_degree.
  localparam int unsigned SCALE_NUM_W = 23;
  localparam logic [SCALE_NUM_W-1:0] SCALE_NUM = 23'd6553600;

  // Divider dividend width: |delta| <= 65535 for any turn size, times SCALE_NUM,
  // stays below 2^39
  localparam int unsigned DIV_W   = 39;
  localparam int unsigned DIVR_W  = 16;
  localparam int unsigned DCNT_W  = $clog2(DIV_W);

  // Saturation bound of the angle, centidegrees with 8 fraction bits
  localparam logic signed [39:0] ANGLE_LIMIT = 40'sd850000000;

  // Reply and command codes
  localparam logic [7:0] CODE_ENCODER = 8'h90;
  localparam logic [7:0] CODE_MOVE    = 8'hA8;
  localparam logic [3:0] DLC_FULL     = 4'd8;

  // Configuration reset values
  localparam logic [10:0]        NODE_ID_RST  = 11'd1;
  localparam logic [15:0]        CPD_RST      = 16'd46603;
  localparam logic signed [16:0] HARD_MIN_RST = -17'sd36000;
  localparam logic signed [16:0] HARD_MAX_RST = 17'sd36000;

  typedef enum logic [1:0] {
    OP_FRAME  = 2'd0,
    OP_MOVE   = 2'd1,
    OP_CMD    = 2'd2,
    OP_TXDONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_NOT_READY = 3'd2,
    ST_BUSY      = 3'd3,
    ST_IGNORED   = 3'd4
  } status_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_NODE_ID      = 3'd0,
    CFG_CENTER_COUNT = 3'd1,
    CFG_CENTER_ANGLE = 3'd2,
    CFG_DIRECTION    = 3'd3,
    CFG_CPD          = 3'd4,
    CFG_HARD_MIN     = 3'd5,
    CFG_HARD_MAX     = 3'd6
  } cfg_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the input beat
    logic mul;        // register |delta| * SCALE_NUM
    logic div_start;  // launch the divider
    logic scale;      // register the saturated angle
    logic commit;     // update state and fill the output register
  } mcfc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_conv;  // captured item is an in-range encoder reply for this node
    logic div_done;   // divider quotient ready
    logic slot_free;  // output register can take a beat
  } mcfc_stat_t;

endpackage

// ===== hdl/mcfc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on mcfc_pkg for DIV_W, DIVR_W and DCNT_W.
module mcfc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mcfc_pkg::DIV_W-1:0]  dividend_i,
  input  logic [mcfc_pkg::DIVR_W-1:0] divisor_i,
  output logic [mcfc_pkg::DIV_W-1:0]  quotient_o,
  output logic                        done_o
);
  import mcfc_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]  acc_q;
  logic [DIVR_W-1:0] rem_q;
  logic [DIVR_W-1:0] dvs_q;

  logic [DIVR_W:0]   trial;
  logic              fits;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_q, acc_q[DIV_W-1]};
    fits  = (trial >= {1'b0, dvs_q});
  end

  // Control: busy flag, step counter, done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DCNT_W'(1);
        if (cnt_q == DCNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Data: remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[DIV_W-2:0], fits};
      rem_q <= fits ? DIVR_W'(trial - {1'b0, dvs_q}) : trial[DIVR_W-1:0];
    end
  end

  assign quotient_o = acc_q;
  assign done_o     = done_q;

endmodule

// ===== hdl/mcfc_ctrl.sv =====
// Sequencer for the motor CAN block: input handshake and step order.
// Depends on mcfc_pkg for the command and status structs.
module mcfc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mcfc_pkg::mcfc_stat_t  stat_i,
  output mcfc_pkg::mcfc_cmd_t   cmd_o
);
  import mcfc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_START = 6'b000100,
    S_DIV   = 6'b001000,
    S_SCALE = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.mul = 1'b1;
        state_d   = stat_i.need_conv ? S_START : S_EMIT;
      end
      S_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== hdl/mcfc_dp.sv =====
// Datapath: configuration, captured beat, feedback state, angle conversion
// and the output register. Depends on mcfc_pkg and mcfc_div.
module mcfc_dp #(
  parameter int unsigned COUNTS_PER_REV = 65536,
  parameter int unsigned MAX_COUNT      = 65535
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [mcfc_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [mcfc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input beat
  input  logic [mcfc_pkg::TDATA_IN_W-1:0]      in_data_i,
  input  logic [mcfc_pkg::TUSER_IN_W-1:0]      in_user_i,
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [mcfc_pkg::TDATA_OUT_W-1:0]     m_axis_tdata_o,
  // controller link
  input  mcfc_pkg::mcfc_cmd_t                  cmd_i,
  output mcfc_pkg::mcfc_stat_t                 stat_o
);
  import mcfc_pkg::*;

  localparam logic signed [17:0] CPR_S  = 18'(COUNTS_PER_REV);
  localparam logic signed [17:0] HALF_S = 18'(COUNTS_PER_REV / 2);
  localparam logic [15:0]        MAX_C  = 16'(MAX_COUNT);

  // Configuration registers
  logic [10:0]        node_q;
  logic [15:0]        center_q;
  logic signed [16:0] center_ang_q;
  logic [1:0]         dir_q;
  logic [15:0]        cpd_q;
  logic signed [16:0] hmin_q;
  logic signed [16:0] hmax_q;

  // Captured beat
  op_e                op_q;
  logic [10:0]        id_q;
  logic               ext_q;
  logic [3:0]         dlc_q;
  logic [63:0]        data_q;
  logic signed [16:0] tgt_q;
  logic [15:0]        spd_q;
  logic [7:0]         code_q;

  // Block state
  logic               tx_busy_q, tx_busy_d;
  logic               have_fb_q, have_fb_d;
  logic signed [31:0] angle_q, angle_d;
  logic [15:0]        enc_cnt_q, enc_cnt_d;
  logic [15:0]        enc_raw_q, enc_raw_d;
  logic [15:0]        enc_off_q, enc_off_d;
  logic [7:0]         temp_q, temp_d;
  logic [15:0]        power_q, power_d;
  logic [15:0]        speed_q, speed_d;
  logic [31:0]        rx_cnt_q, rx_cnt_d;

  // Conversion pipeline
  logic [DIV_W-1:0]   prod_q;
  logic               neg_q;
  logic signed [31:0] conv_q;
  logic [DIV_W-1:0]   quo;
  logic               div_done;

  // Output register
  logic                   m_valid_q;
  logic [TDATA_OUT_W-1:0] m_data_q, m_data_d;

  // Frame decode
  logic        frame_ok;
  logic        is_enc;
  logic [15:0] raw;
  logic        raw_ok;

  // Delta and product
  logic signed [17:0] d_raw, d_wrap, d_abs;
  logic [15:0]        mag;
  logic [38:0]        prod_full;

  // Scaling
  logic               q_neg;
  logic signed [39:0] q_s, a_full;
  logic signed [31:0] a_sat;

  // Move amount
  logic signed [33:0] diff, md, md_abs, rnd, ctl;

  // Step result
  status_e     status;
  logic        txv;
  logic [63:0] txd;
  logic [63:0] send;
  logic        want_send;

  // Capture config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q       <= NODE_ID_RST;
      center_q     <= '0;
      center_ang_q <= '0;
      dir_q        <= '0;
      cpd_q        <= CPD_RST;
      hmin_q       <= HARD_MIN_RST;
      hmax_q       <= HARD_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_addr_i))
        CFG_NODE_ID:      node_q       <= cfg_data_i[10:0];
        CFG_CENTER_COUNT: center_q     <= cfg_data_i[15:0];
        CFG_CENTER_ANGLE: center_ang_q <= $signed(cfg_data_i[16:0]);
        CFG_DIRECTION:    dir_q        <= cfg_data_i[1:0];
        CFG_CPD:          cpd_q        <= cfg_data_i[15:0];
        CFG_HARD_MIN:     hmin_q       <= $signed(cfg_data_i[16:0]);
        CFG_HARD_MAX:     hmax_q       <= $signed(cfg_data_i[16:0]);
        default: ;
      endcase
    end
  end

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(in_user_i[1:0]);
      id_q   <= in_data_i[10:0];
      ext_q  <= in_data_i[11];
      dlc_q  <= in_data_i[15:12];
      data_q <= in_data_i[79:16];
      tgt_q  <= $signed(in_data_i[96:80]);
      spd_q  <= in_data_i[112:97];
      code_q <= in_data_i[120:113];
    end
  end

  // Decode the received frame
  always_comb begin
    frame_ok = (op_q == OP_FRAME) && !ext_q && (id_q == node_q) && (dlc_q == DLC_FULL);
    is_enc   = (data_q[7:0] == CODE_ENCODER);
    raw      = data_q[47:32];
    raw_ok   = (raw <= MAX_C);
  end

  // Wrapped delta from the center count and its scaled magnitude
  always_comb begin
    d_raw = $signed({2'b00, raw}) - $signed({2'b00, center_q});
    if (d_raw > HALF_S) begin
      d_wrap = d_raw - CPR_S;
    end else if (d_raw < -HALF_S) begin
      d_wrap = d_raw + CPR_S;
    end else begin
      d_wrap = d_raw;
    end
    d_abs     = d_wrap[17] ? -d_wrap : d_wrap;
    mag       = d_abs[15:0];
    prod_full = {23'b0, mag} * {16'b0, SCALE_NUM};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_full[DIV_W-1:0];
      neg_q  <= d_wrap[17];
    end
  end

  // Divide by counts_per_degree, zero taken as one
  mcfc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  ((cpd_q == 16'd0) ? 16'd1 : cpd_q),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  // Apply direction, add the center angle, saturate
  always_comb begin
    q_neg  = neg_q ^ dir_q[1];
    if (dir_q == 2'b00) begin
      q_s = '0;
    end else if (q_neg) begin
      q_s = -$signed({1'b0, quo});
    end else begin
      q_s = $signed({1'b0, quo});
    end
    a_full = (40'(center_ang_q) <<< 8) + q_s;
    if (a_full > ANGLE_LIMIT) begin
      a_sat = 32'(ANGLE_LIMIT);
    end else if (a_full < -ANGLE_LIMIT) begin
      a_sat = 32'(-ANGLE_LIMIT);
    end else begin
      a_sat = 32'(a_full);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      conv_q <= a_sat;
    end
  end

  // Relative move rounded half away from zero
  always_comb begin
    diff   = (34'(tgt_q) <<< 8) - 34'(angle_q);
    md     = dir_q[1] ? -diff : diff;
    md_abs = md[33] ? -md : md;
    rnd    = (md_abs + 34'sd128) >>> 8;
    ctl    = md[33] ? -rnd : rnd;
  end

  // Evaluate the step and the next block state
  always_comb begin
    status    = ST_OK;
    txv       = 1'b0;
    txd       = '0;
    send      = '0;
    want_send = 1'b0;
    tx_busy_d = tx_busy_q;
    have_fb_d = have_fb_q;
    angle_d   = angle_q;
    enc_cnt_d = enc_cnt_q;
    enc_raw_d = enc_raw_q;
    enc_off_d = enc_off_q;
    temp_d    = temp_q;
    power_d   = power_q;
    speed_d   = speed_q;
    rx_cnt_d  = rx_cnt_q;
    case (op_q)
      OP_FRAME: begin
        if (!frame_ok) begin
          status = ST_IGNORED;
        end else if (is_enc) begin
          enc_cnt_d = data_q[31:16];
          enc_raw_d = data_q[47:32];
          enc_off_d = data_q[63:48];
          if (!raw_ok) begin
            status = ST_IGNORED;
          end else begin
            angle_d   = conv_q;
            have_fb_d = 1'b1;
            rx_cnt_d  = rx_cnt_q + 32'd1;
          end
        end else begin
          temp_d    = data_q[15:8];
          power_d   = data_q[31:16];
          speed_d   = data_q[47:32];
          enc_cnt_d = data_q[63:48];
          rx_cnt_d  = rx_cnt_q + 32'd1;
        end
      end
      OP_MOVE: begin
        if ((tgt_q < hmin_q) || (tgt_q > hmax_q) || (spd_q == 16'd0)) begin
          status = ST_RANGE;
        end else if (!have_fb_q || (dir_q == 2'b00)) begin
          status = ST_NOT_READY;
        end else if (ctl != 34'sd0) begin
          send      = {ctl[31:0], spd_q, 8'h00, CODE_MOVE};
          want_send = 1'b1;
        end
      end
      OP_CMD: begin
        send      = {56'b0, code_q};
        want_send = 1'b1;
      end
      OP_TXDONE: begin
        tx_busy_d = 1'b0;
      end
      default: ;
    endcase
    // One frame in flight at a time
    if (want_send) begin
      if (tx_busy_q) begin
        status = ST_BUSY;
      end else begin
        tx_busy_d = 1'b1;
        txv       = 1'b1;
        txd       = send;
      end
    end
    m_data_d = {4'b0, rx_cnt_d, speed_d, power_d, temp_d, enc_off_d, enc_raw_d,
                enc_cnt_d, have_fb_d, angle_d[30:0], txd, txv, status};
  end

  // Commit the block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_busy_q <= 1'b0;
      have_fb_q <= 1'b0;
      angle_q   <= '0;
      enc_cnt_q <= '0;
      enc_raw_q <= '0;
      enc_off_q <= '0;
      temp_q    <= '0;
      power_q   <= '0;
      speed_q   <= '0;
      rx_cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      tx_busy_q <= tx_busy_d;
      have_fb_q <= have_fb_d;
      angle_q   <= angle_d;
      enc_cnt_q <= enc_cnt_d;
      enc_raw_q <= enc_raw_d;
      enc_off_q <= enc_off_d;
      temp_q    <= temp_d;
      power_q   <= power_d;
      speed_q   <= speed_d;
      rx_cnt_q  <= rx_cnt_d;
    end
  end

  // Output register: load on commit, drop when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  assign stat_o.need_conv = frame_ok && is_enc && raw_ok;
  assign stat_o.div_done  = div_done;
  assign stat_o.slot_free = !m_valid_q || m_axis_tready_i;

  // Commit never overwrites a beat still waiting at the output
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!m_valid_q || m_axis_tready_i))
    else $error("commit while output beat pending");

  // The transmit-busy flag only rises through a commit
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tx_busy_q) |-> $past(cmd_i.commit))
    else $error("tx busy set outside commit");

  // Feedback, once taken, stays valid
  a_fb_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_fb_q |=> have_fb_q)
    else $error("feedback valid cleared");

  // One beat at a time
  a_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> !cmd_i.load)
    else $error("back-to-back input capture");

endmodule

// ===== hdl/motor_can_feedback_and_command.sv =====
// Top level of the motor CAN feedback and command block.
// Depends on mcfc_pkg, mcfc_ctrl and mcfc_dp (which holds mcfc_div).
//
// Usage:
//   Input stream (s_axis): one beat per operation. tuser carries the op code
//   (received frame, position request, simple command, transmit done); tdata
//   carries the frame fields, the target and speed, and the command byte.
//   Output stream (m_axis): exactly one result beat per input beat, in order,
//   with the status, the frame to transmit and the feedback/telemetry state.
//   Configuration port: cfg_we_i writes register cfg_addr_i; write only while
//   no item is in progress.
//   Timing: a beat is taken only in the idle state. Items without angle
//   conversion pass the check and emit states; an in-range encoder reply
//   also passes the start, divide and scale states, with the 39-step
//   bit-serial divider, before its result is registered. The next beat is
//   taken in the cycle after the result is registered, so no new beat is
//   taken while an item is still being worked.
//   Reset: configuration returns to its defaults, feedback and telemetry
//   clear, no frame is pending and the output is empty.
//   Stall: a result waits in the output register; one more item is taken and
//   worked, then held until the receiver takes the waiting beat.
module motor_can_feedback_and_command #(
  parameter int unsigned COUNTS_PER_REV = 65536,
  parameter int unsigned MAX_COUNT      = 65535
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [mcfc_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [mcfc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // frame_id[10:0], frame_extended[11], frame_dlc[15:12], frame_data[79:16],
  // target_angle[96:80], max_speed[112:97], command_code[120:113], zero[127:121]
  input  logic [mcfc_pkg::TDATA_IN_W-1:0]    s_axis_tdata_i,
  // op[1:0]
  input  logic [mcfc_pkg::TUSER_IN_W-1:0]    s_axis_tuser_i,
  // result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // status[2:0], tx_valid[3], tx_data[67:4], angle_now[98:68],
  // fb_valid[99], enc_count[115:100], enc_raw[131:116],
  // enc_offset[147:132], temperature[155:148], power[171:156],
  // speed[187:172], reply_count[219:188], zero[223:220]
  output logic [mcfc_pkg::TDATA_OUT_W-1:0]   m_axis_tdata_o
);
  import mcfc_pkg::*;

  mcfc_cmd_t  cmd;
  mcfc_stat_t stat;

  mcfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mcfc_dp #(
    .COUNTS_PER_REV (COUNTS_PER_REV),
    .MAX_COUNT      (MAX_COUNT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .in_data_i       (s_axis_tdata_i),
    .in_user_i       (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule

// ===== tb/sv/tb_motor_can_feedback_and_command.sv =====
// Self-checking testbench for motor_can_feedback_and_command: directed and random beats
// are predicted in-bench and each result beat is compared field by field.
// Depends on mcfc_pkg and the motor_can_feedback_and_command RTL.
module tb_motor_can_feedback_and_command;
  timeunit 1ns;
  timeprecision 1ps;

  import mcfc_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int MAX_SHOWN    = 10;
  localparam int TAIL_CYCLES  = 60;

  // Input beat, lowest field last
  typedef struct packed {
    logic [6:0]  pad;
    logic [7:0]  code;
    logic [15:0] max_speed;
    logic [16:0] target;
    logic [63:0] data;
    logic [3:0]  dlc;
    logic        ext;
    logic [10:0] id;
  } motor_req_t;

  // Result beat, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] reply_cnt;
    logic [15:0] speed;
    logic [15:0] power;
    logic [7:0]  temperature;
    logic [15:0] enc_offset;
    logic [15:0] enc_raw;
    logic [15:0] enc_count;
    logic        fb_valid;
    logic [30:0] angle_now;
    logic [63:0] tx_data;
    logic        tx_valid;
    logic [2:0]  status;
  } motor_rsp_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [TDATA_IN_W-1:0]   s_tdata = '0;
  logic [TUSER_IN_W-1:0]   s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0]  m_tdata;

  // Shadow of the configuration registers
  logic [10:0] cfg_node   = NODE_ID_RST;
  logic [15:0] cfg_ccount = '0;
  logic [16:0] cfg_cangle = '0;
  logic [1:0]  cfg_dir    = '0;
  logic [15:0] cfg_cpd    = CPD_RST;
  logic [16:0] cfg_hmin   = HARD_MIN_RST;
  logic [16:0] cfg_hmax   = HARD_MAX_RST;

  // Predicted node state
  logic        busy_tx     = 1'b0;
  logic        fb_valid    = 1'b0;
  int          angle_q8    = 0;
  logic [15:0] enc_count   = '0;
  logic [15:0] enc_raw     = '0;
  logic [15:0] enc_offset  = '0;
  logic [7:0]  temp_c      = '0;
  logic [15:0] power_v     = '0;
  logic [15:0] speed_v     = '0;
  logic [31:0] reply_total = '0;

  motor_rsp_t rsp_due_q[$];
  motor_rsp_t rsp_got, rsp_want;

  int mismatches  = 0;
  int n_items     = 0;
  int n_results   = 0;
  int n_sent      = 0;
  int n_conv      = 0;
  int n_writes    = 0;
  int cycle_cnt   = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left   = 0;

  motor_can_feedback_and_command dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt, rsp_due_q.size());
      $display("motor_can_feedback_and_command: mismatch");
      $finish;
    end
  end

  // Receiver: long hold-off when requested, else random stalls
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic int dir_sign();
    return ($signed(cfg_dir) < 0) ? -1 : (($signed(cfg_dir) > 0) ? 1 : 0);
  endfunction

  // Encoder count to angle in centidegrees with 8 fraction bits, saturated
  function automatic int scale_encoder(logic [15:0] raw);
    longint d, c, q, a;
    d = longint'(raw) - longint'(cfg_ccount);
    if (d > 32768) d -= 65536;
    else if (d < -32768) d += 65536;
    c = (cfg_cpd == 0) ? 64'sd1 : longint'(cfg_cpd);
    q = (d * 6553600) / c;
    a = longint'($signed(cfg_cangle)) * 256 + dir_sign() * q;
    if (a > 850000000) a = 850000000;
    if (a < -850000000) a = -850000000;
    return int'(a);
  endfunction

  // Advance the predicted state by one beat and return the expected result
  function automatic motor_rsp_t model_item(op_e op, motor_req_t rq);
    motor_rsp_t  r;
    logic [63:0] frame;
    logic        want;
    longint      tgt, md, ctl;
    int          ds;
    r     = '0;
    frame = '0;
    want  = 1'b0;
    ds    = dir_sign();
    case (op)
      OP_FRAME: begin
        if (rq.ext || rq.id != cfg_node || rq.dlc != DLC_FULL) begin
          r.status = ST_IGNORED;
        end else if (rq.data[7:0] == CODE_ENCODER) begin
          enc_count  = rq.data[31:16];
          enc_raw    = rq.data[47:32];
          enc_offset = rq.data[63:48];
          angle_q8   = scale_encoder(enc_raw);
          fb_valid   = 1'b1;
          reply_total++;
          n_conv++;
        end else begin
          temp_c    = rq.data[15:8];
          power_v   = rq.data[31:16];
          speed_v   = rq.data[47:32];
          enc_count = rq.data[63:48];
          reply_total++;
        end
      end
      OP_MOVE: begin
        tgt = longint'($signed(rq.target));
        if (tgt < longint'($signed(cfg_hmin)) || tgt > longint'($signed(cfg_hmax)) ||
            rq.max_speed == 0) begin
          r.status = ST_RANGE;
        end else if (!fb_valid || ds == 0) begin
          r.status = ST_NOT_READY;
        end else begin
          md  = (tgt * 256 - longint'(angle_q8)) * ds;
          ctl = (md >= 0) ? (md + 128) / 256 : -((-md + 128) / 256);
          if (ctl != 0) begin
            frame = {ctl[31:0], rq.max_speed, 8'h00, CODE_MOVE};
            want  = 1'b1;
          end
        end
      end
      OP_CMD: begin
        frame = {56'd0, rq.code};
        want  = 1'b1;
      end
      default: begin
        busy_tx = 1'b0;
      end
    endcase
    if (want) begin
      if (busy_tx) begin
        r.status = ST_BUSY;
      end else begin
        busy_tx   = 1'b1;
        r.tx_valid = 1'b1;
        r.tx_data  = frame;
        n_sent++;
      end
    end
    r.angle_now   = angle_q8[30:0];
    r.fb_valid    = fb_valid;
    r.enc_count   = enc_count;
    r.enc_raw     = enc_raw;
    r.enc_offset  = enc_offset;
    r.temperature = temp_c;
    r.power       = power_v;
    r.speed       = speed_v;
    r.reply_cnt   = reply_total;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("result %0d: %s expected %h, got %h", n_results, name, want, got);
    end
  endtask

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      rsp_got = m_tdata;
      if (rsp_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("result beat %h arrived with nothing due", m_tdata);
      end else begin
        rsp_want = rsp_due_q.pop_front();
        check_field("status", rsp_want.status, rsp_got.status);
        check_field("tx_valid", rsp_want.tx_valid, rsp_got.tx_valid);
        check_field("tx_data", rsp_want.tx_data, rsp_got.tx_data);
        check_field("angle_now", rsp_want.angle_now, rsp_got.angle_now);
        check_field("fb_valid", rsp_want.fb_valid, rsp_got.fb_valid);
        check_field("enc_count", rsp_want.enc_count, rsp_got.enc_count);
        check_field("enc_raw", rsp_want.enc_raw, rsp_got.enc_raw);
        check_field("enc_offset", rsp_want.enc_offset, rsp_got.enc_offset);
        check_field("temperature", rsp_want.temperature, rsp_got.temperature);
        check_field("power", rsp_want.power, rsp_got.power);
        check_field("speed", rsp_want.speed, rsp_got.speed);
        check_field("reply_count", rsp_want.reply_cnt, rsp_got.reply_cnt);
        n_results++;
      end
    end
  end

  // Offer one beat, with random gaps ahead of it, and predict it once taken
  task automatic send_item(op_e op, motor_req_t rq);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rq;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    rsp_due_q.push_back(model_item(op, rq));
    n_items++;
  endtask

  // Stop offering and wait for every due result
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (rsp_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_e idx, logic [16:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_NODE_ID:      cfg_node   = val[10:0];
      CFG_CENTER_COUNT: cfg_ccount = val[15:0];
      CFG_CENTER_ANGLE: cfg_cangle = val;
      CFG_DIRECTION:    cfg_dir    = val[1:0];
      CFG_CPD:          cfg_cpd    = val[15:0];
      CFG_HARD_MIN:     cfg_hmin   = val;
      CFG_HARD_MAX:     cfg_hmax   = val;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random content in every field but the zero pad
  function automatic motor_req_t noise_req();
    motor_req_t rq;
    rq.pad       = '0;
    rq.code      = 8'($urandom);
    rq.max_speed = 16'($urandom);
    rq.target    = 17'($urandom);
    rq.data      = {$urandom, $urandom};
    rq.dlc       = 4'($urandom);
    rq.ext       = 1'($urandom);
    rq.id        = 11'($urandom);
    return rq;
  endfunction

  function automatic motor_req_t frame_req(logic [10:0] id, logic ext, logic [3:0] dlc,
                                           logic [63:0] data);
    motor_req_t rq;
    rq      = noise_req();
    rq.id   = id;
    rq.ext  = ext;
    rq.dlc  = dlc;
    rq.data = data;
    return rq;
  endfunction

  function automatic motor_req_t enc_req(logic [15:0] raw);
    return frame_req(cfg_node, 1'b0, DLC_FULL,
                     {16'($urandom), raw, 16'($urandom), 8'($urandom), CODE_ENCODER});
  endfunction

  function automatic motor_req_t move_req(int tgt, int spd);
    motor_req_t rq;
    rq           = noise_req();
    rq.target    = 17'(tgt);
    rq.max_speed = 16'(spd);
    return rq;
  endfunction

  function automatic motor_req_t cmd_req(logic [7:0] code);
    motor_req_t rq;
    rq      = noise_req();
    rq.code = code;
    return rq;
  endfunction

  // Mostly well-formed traffic for this node, some foreign or broken frames
  task automatic rand_item(output op_e op, output motor_req_t rq);
    int sel, lo, hi;
    rq  = noise_req();
    sel = $urandom_range(99);
    lo  = $signed(cfg_hmin);
    hi  = $signed(cfg_hmax);
    if (sel < 38) begin
      op     = OP_FRAME;
      rq.id  = cfg_node;
      rq.ext = 1'b0;
      rq.dlc = DLC_FULL;
      if ($urandom_range(9) < 6) begin
        rq.data[7:0] = CODE_ENCODER;
        if ($urandom_range(1) == 1)
          rq.data[47:32] = cfg_ccount + 16'($urandom_range(4000)) - 16'd2000;
      end
    end else if (sel < 46) begin
      op = OP_FRAME;
      if ($urandom_range(3) == 0) rq.id = cfg_node;
    end else if (sel < 70) begin
      op = OP_MOVE;
      if ($urandom_range(15) == 0) rq.max_speed = '0;
      else if (rq.max_speed == 0) rq.max_speed = 16'd1;
      if ($urandom_range(9) < 8 && lo <= hi)
        rq.target = 17'(lo + int'($urandom_range(hi - lo)));
    end else if (sel < 84) begin
      op = OP_CMD;
    end else begin
      op = OP_TXDONE;
    end
  endtask

  // Pick a fresh setting of every register
  task automatic rand_config();
    int a, b, sel;
    write_reg(CFG_NODE_ID, 17'($urandom_range(2047)));
    write_reg(CFG_CENTER_COUNT, 17'($urandom_range(65535)));
    if ($urandom_range(9) == 0) write_reg(CFG_CENTER_ANGLE, 17'($urandom));
    else write_reg(CFG_CENTER_ANGLE, 17'(int'($urandom_range(72000)) - 36000));
    sel = $urandom_range(9);
    if (sel < 4) write_reg(CFG_DIRECTION, 17'd1);
    else if (sel < 8) write_reg(CFG_DIRECTION, 17'h1FFFF);
    else if (sel == 8) write_reg(CFG_DIRECTION, 17'd0);
    else write_reg(CFG_DIRECTION, 17'd2);
    if ($urandom_range(9) == 0) write_reg(CFG_CPD, 17'($urandom_range(255)));
    else write_reg(CFG_CPD, 17'($urandom_range(65535, 256)));
    a = int'($urandom_range(72000)) - 36000;
    b = int'($urandom_range(72000)) - 36000;
    sel = $urandom_range(9);
    if (sel == 0) begin
      a = $signed(17'($urandom));
      b = $signed(17'($urandom));
    end else if (sel == 1) begin
      a = -65536;
      b = 65535;
    end else if (sel > 2 && a > b) begin
      a = a + b;
      b = a - b;
      a = a - b;
    end
    write_reg(CFG_HARD_MIN, 17'(a));
    write_reg(CFG_HARD_MAX, 17'(b));
  endtask

  // Reset defaults: idle done, no feedback yet, frames that must be ignored and a status reply
  task automatic test_after_reset();
    send_item(OP_TXDONE, noise_req());
    send_item(OP_MOVE, move_req(0, 100));
    send_item(OP_FRAME, frame_req(cfg_node, 1'b1, DLC_FULL, {$urandom, $urandom}));
    send_item(OP_FRAME, frame_req(cfg_node + 11'd1, 1'b0, DLC_FULL, {$urandom, $urandom}));
    send_item(OP_FRAME, frame_req(cfg_node, 1'b0, 4'hF, {$urandom, $urandom}));
    send_item(OP_FRAME, frame_req(cfg_node, 1'b0, DLC_FULL,
                                  {$urandom, 24'($urandom), 8'h9C}));
    drain();
  endtask

  // Encoder delta right at and just past half a turn, and across zero
  task automatic test_encoder_wrap();
    write_reg(CFG_NODE_ID, 17'd2047);
    write_reg(CFG_DIRECTION, 17'd1);
    write_reg(CFG_CENTER_COUNT, 17'd0);
    send_item(OP_FRAME, enc_req(16'h8000));
    send_item(OP_FRAME, enc_req(16'h8001));
    drain();
    write_reg(CFG_CENTER_COUNT, 17'h0FFFF);
    send_item(OP_FRAME, enc_req(16'h0000));
    drain();
  endtask

  // Zero scale, extreme centre angles and direction -2; the angle saturates at the negative limit
  task automatic test_saturation();
    write_reg(CFG_NODE_ID, 17'd0);
    write_reg(CFG_CPD, 17'd0);
    write_reg(CFG_CENTER_ANGLE, 17'h0FFFF);
    write_reg(CFG_DIRECTION, 17'd2);
    send_item(OP_FRAME, enc_req(16'h0064));
    drain();
    write_reg(CFG_CPD, 17'd1);
    write_reg(CFG_CENTER_ANGLE, 17'h10000);
    write_reg(CFG_DIRECTION, 17'd1);
    send_item(OP_FRAME, enc_req(16'h7FFF));
    send_item(OP_MOVE, move_req(36000, 65535));
    send_item(OP_TXDONE, noise_req());
    drain();
  endtask

  // Rounding at a half step, zero move, range checks, busy and plain commands
  task automatic test_moves();
    write_reg(CFG_CPD, 17'd51200);
    write_reg(CFG_CENTER_COUNT, 17'h01234);
    write_reg(CFG_CENTER_ANGLE, 17'd100);
    write_reg(CFG_HARD_MIN, 17'(-200));
    write_reg(CFG_HARD_MAX, 17'd300);
    send_item(OP_FRAME, enc_req(16'h1235));
    send_item(OP_MOVE, move_req(100, 1));
    send_item(OP_MOVE, move_req(300, 65535));
    send_item(OP_TXDONE, noise_req());
    send_item(OP_MOVE, move_req(301, 10));
    send_item(OP_MOVE, move_req(-201, 10));
    send_item(OP_MOVE, move_req(300, 0));
    send_item(OP_FRAME, enc_req(16'h1234));
    send_item(OP_MOVE, move_req(100, 7));
    send_item(OP_MOVE, move_req(300, 65535));
    send_item(OP_CMD, cmd_req(8'hFF));
    send_item(OP_TXDONE, noise_req());
    send_item(OP_CMD, cmd_req(8'h00));
    drain();
    write_reg(CFG_DIRECTION, 17'd0);
    send_item(OP_MOVE, move_req(100, 7));
    drain();
  endtask

  // Receiver holds off long enough for the block to back up its input
  task automatic test_backpressure();
    op_e        op;
    motor_req_t rq;
    rand_config();
    hold_left = 400;
    repeat (12) begin
      rand_item(op, rq);
      send_item(op, rq);
    end
    drain();
  endtask

  task automatic test_random(int count, int tx_pct, int rx_pct);
    op_e        op;
    motor_req_t rq;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    rand_config();
    repeat (count) begin
      rand_item(op, rq);
      send_item(op, rq);
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 8;
    rx_idle_pct = 54;
    test_after_reset();
    test_encoder_wrap();
    test_saturation();
    test_moves();
    test_backpressure();
    test_random(85, 8, 54);
    test_random(85, 8, 54);
    test_random(85, 54, 8);
    test_random(85, 54, 8);
    test_random(85, 0, 0);
    test_random(85, 0, 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d beats in, %0d results checked, %0d register writes",
             n_items, n_results, n_writes);
    $display("%0d angle conversions, %0d frames sent, %0d field mismatches",
             n_conv, n_sent, mismatches);
    if (mismatches == 0 && rsp_due_q.size() == 0) begin
      $display("motor_can_feedback_and_command: match");
    end else begin
      $display("motor_can_feedback_and_command: mismatch");
    end
    $finish;
  end

endmodule
